FILE: design/smd_pkg.sv
// shared types, codes and constants of the seven-segment multiplexer
// no dependencies; used by the channel interfaces and the top level

package smd_pkg;

  // field widths
  localparam int unsigned ValueW   = 16;
  localparam int unsigned NumW     = 14;
  localparam int unsigned SegW     = 8;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned PosW     = 2;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  // largest number the display can hold
  localparam logic [NumW-1:0] MaxNumber = 14'd9999;

  // operation codes
  typedef enum logic [0:0] {
    OP_SET     = 1'b0,
    OP_REFRESH = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DIGITS   = 2'd0,
    CFG_POINT_ENABLE = 2'd1,
    CFG_POINT_BIT    = 2'd2
  } cfg_idx_e;

  // configuration reset values
  localparam logic [2:0] MinDigitsRst   = 3'd1;
  localparam logic [3:0] PointEnableRst = 4'd0;
  localparam logic [2:0] PointBitRst    = 3'd2;

  // reciprocal constants for division by 10, 100 and 1000 (exact below 10000)
  localparam int unsigned ProdW     = 30;
  localparam logic [ProdW-1:0] Recip10   = 30'd6554;
  localparam logic [ProdW-1:0] Recip100  = 30'd10486;
  localparam logic [ProdW-1:0] Recip1000 = 30'd16778;
  localparam int unsigned Shift10   = 16;
  localparam int unsigned Shift100  = 20;
  localparam int unsigned Shift1000 = 24;

  typedef logic [DigitW-1:0] digit_t;

  // segment pattern of one decimal digit
  function automatic logic [SegW-1:0] seg_lookup(input digit_t d);
    logic [SegW-1:0] s;
    begin
      case (d)
        4'd0:    s = 8'heb;
        4'd1:    s = 8'h28;
        4'd2:    s = 8'hb3;
        4'd3:    s = 8'hba;
        4'd4:    s = 8'h78;
        4'd5:    s = 8'hda;
        4'd6:    s = 8'hdb;
        4'd7:    s = 8'he8;
        4'd8:    s = 8'hfb;
        4'd9:    s = 8'hfa;
        default: s = 8'h00;
      endcase
      return s;
    end
  endfunction

endpackage

FILE: design/smd_in_if.sv
// input channel of the seven-segment multiplexer: valid/ready plus item fields
// depends on smd_pkg for the field widths

interface smd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [smd_pkg::ValueW-1:0]    value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

FILE: design/smd_out_if.sv
// result channel of the seven-segment multiplexer: valid/ready plus result fields
// depends on smd_pkg for the field widths

interface smd_out_if;
  logic                            valid;
  logic                            ready;
  logic [smd_pkg::SegW-1:0]        segments;
  logic [smd_pkg::NumDigits-1:0]   digit_ground_n;
  logic [smd_pkg::PosW-1:0]        digit_position;

  modport source (output valid, output segments, output digit_ground_n,
                  output digit_position, input ready);
  modport sink   (input valid, input segments, input digit_ground_n,
                  input digit_position, output ready);
endinterface

FILE: design/seven_segment_mux_driver.sv
// top level of the four-digit seven-segment multiplexer
// depends on smd_pkg, smd_in_if and smd_out_if

// Usage
// in_i carries one transaction per item: operation set stores value clamped
// to 9999, operation refresh services the next of four digit positions.
// out_o returns one transaction per refresh: the segment byte, the active-low
// digit grounds (all high for a blanked leading zero, segments then repeat the
// previous byte) and the serviced position. A set returns nothing.
// Configuration (min_digits, point_enable, point_bit) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i while no transaction is in flight.
// An accepted item is held in the input register; a refresh result is loaded
// into the result register as the item leaves it, once that register is free,
// and is then on out_o. Throughput is one item per cycle while out_o does not
// stall, set by the input register feeding the result register.
// A set converts the number to four decimal digits while it sits in the input
// register; the digits load as it leaves, so a following refresh sees them.
// Reset clears both stages, the scan position to 0, the stored number to 0,
// the last segment byte to 0 and the registers to their defaults.
// When out_o stalls, the result register holds, one more item waits in the
// input register and in_i deasserts ready behind it; sets still drain.

module seven_segment_mux_driver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  smd_in_if.sink                         in_i,
  smd_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [smd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [smd_pkg::CfgDataW-1:0]   cfg_data_i
);

  // configuration registers
  logic [2:0] min_digits_q;
  logic [3:0] point_en_q;
  logic [2:0] point_bit_q;

  // input register
  logic                        s1_vld_q;
  logic                        s1_op_q;
  logic [smd_pkg::NumW-1:0]    s1_num_q;
  logic [smd_pkg::NumW-1:0]    s1_num_d;

  // display state
  smd_pkg::digit_t             digit_q [smd_pkg::NumDigits];
  smd_pkg::digit_t             digit_d [smd_pkg::NumDigits];
  logic [smd_pkg::PosW-1:0]    scan_pos_q;
  logic [smd_pkg::SegW-1:0]    last_seg_q;

  // result register
  logic                            out_vld_q;
  logic [smd_pkg::NumDigits-1:0]   ground_q;
  logic [smd_pkg::PosW-1:0]        pos_q;

  logic out_free;
  logic s2_go;
  logic s2_set;
  logic s2_refresh;

  // number to digit conversion
  logic [smd_pkg::ProdW-1:0] prod10, prod100, prod1000;
  logic [9:0]                 quo10;
  logic [6:0]                 quo100;
  logic [3:0]                 quo1000;
  logic [smd_pkg::NumW-1:0]   rem10;
  logic [9:0]                 rem100;
  logic [6:0]                 rem1000;

  // refresh datapath
  logic                        lead_zero;
  logic                        blank;
  logic [smd_pkg::SegW-1:0]    seg_raw;
  logic [smd_pkg::SegW-1:0]    point_mask;
  logic [smd_pkg::NumDigits-1:0] ground_d;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_digits_q <= smd_pkg::MinDigitsRst;
      point_en_q   <= smd_pkg::PointEnableRst;
      point_bit_q  <= smd_pkg::PointBitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smd_pkg::CFG_MIN_DIGITS:   min_digits_q <= cfg_data_i[2:0];
        smd_pkg::CFG_POINT_ENABLE: point_en_q   <= cfg_data_i;
        smd_pkg::CFG_POINT_BIT:    point_bit_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // handshake: sets drain freely, refreshes need room in the result register
  assign out_free   = !out_vld_q || out_o.ready;
  assign s2_set     = s1_vld_q && (s1_op_q == smd_pkg::OP_SET);
  assign s2_refresh = s1_vld_q && (s1_op_q == smd_pkg::OP_REFRESH) && out_free;
  assign s2_go      = s2_set || s2_refresh;
  assign in_i.ready = !s1_vld_q || s2_go;

  // clamp at the input
  assign s1_num_d = (in_i.value > smd_pkg::ValueW'(smd_pkg::MaxNumber))
                  ? smd_pkg::MaxNumber : in_i.value[smd_pkg::NumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q  <= in_i.operation;
      s1_num_q <= s1_num_d;
    end
  end

  // decimal digits by reciprocal multiplication
  assign prod10   = smd_pkg::ProdW'(s1_num_q) * smd_pkg::Recip10;
  assign prod100  = smd_pkg::ProdW'(s1_num_q) * smd_pkg::Recip100;
  assign prod1000 = smd_pkg::ProdW'(s1_num_q) * smd_pkg::Recip1000;
  assign quo10    = prod10[smd_pkg::Shift10 +: 10];
  assign quo100   = prod100[smd_pkg::Shift100 +: 7];
  assign quo1000  = prod1000[smd_pkg::Shift1000 +: 4];

  // remainders by shift-add times ten
  assign rem10   = s1_num_q - ({4'd0, quo10} << 3) - ({4'd0, quo10} << 1);
  assign rem100  = quo10 - ({3'd0, quo100} << 3) - ({3'd0, quo100} << 1);
  assign rem1000 = quo100 - ({3'd0, quo1000} << 3) - ({3'd0, quo1000} << 1);

  assign digit_d[0] = rem10[smd_pkg::DigitW-1:0];
  assign digit_d[1] = rem100[smd_pkg::DigitW-1:0];
  assign digit_d[2] = rem1000[smd_pkg::DigitW-1:0];
  assign digit_d[3] = quo1000;

  // leading zero test for the current position
  always_comb begin
    case (scan_pos_q)
      2'd1:    lead_zero = (digit_q[3] == '0) && (digit_q[2] == '0) && (digit_q[1] == '0);
      2'd2:    lead_zero = (digit_q[3] == '0) && (digit_q[2] == '0);
      2'd3:    lead_zero = (digit_q[3] == '0);
      default: lead_zero = 1'b0;
    endcase
  end

  assign blank = (scan_pos_q != '0) && lead_zero
              && (min_digits_q < ({1'b0, scan_pos_q} + 3'd1));

  // segment byte with optional decimal point
  assign point_mask = point_en_q[scan_pos_q]
                    ? (smd_pkg::SegW'(1) << point_bit_q) : '0;
  assign seg_raw    = smd_pkg::seg_lookup(digit_q[scan_pos_q]) | point_mask;
  assign ground_d   = blank ? '1 : ~(smd_pkg::NumDigits'(1) << scan_pos_q);

  // display state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < smd_pkg::NumDigits; i++) begin
        digit_q[i] <= '0;
      end
      scan_pos_q <= '0;
      last_seg_q <= '0;
    end else begin
      if (s2_set) begin
        for (int i = 0; i < smd_pkg::NumDigits; i++) begin
          digit_q[i] <= digit_d[i];
        end
      end
      if (s2_refresh) begin
        scan_pos_q <= scan_pos_q + 2'd1;
        if (!blank) begin
          last_seg_q <= seg_raw;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s2_refresh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_refresh) begin
      ground_q <= ground_d;
      pos_q    <= scan_pos_q;
    end
  end

  // segments follow the last byte, which only moves when a result is loaded
  assign out_o.valid          = out_vld_q;
  assign out_o.segments       = last_seg_q;
  assign out_o.digit_ground_n = ground_q;
  assign out_o.digit_position = pos_q;

`ifndef ASSERT_OFF
  // at most one digit ground is driven low
  a_one_ground: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (ground_q == 4'hf || $onehot(~ground_q)))
    else $error("more than one digit ground low");

  // a driven ground matches the serviced position
  a_ground_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && ground_q != 4'hf) |-> !ground_q[pos_q])
    else $error("digit ground does not match position");

  // position zero is never blanked
  a_pos0_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && pos_q == 2'd0) |-> (ground_q == 4'he))
    else $error("position zero blanked");

  // scan position steps by one per refresh
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_refresh |=> (scan_pos_q == 2'($past(scan_pos_q) + 2'd1)))
    else $error("scan position did not advance");

  // stored digits stay decimal
  a_digits_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_q[0] <= 4'd9) && (digit_q[1] <= 4'd9)
    && (digit_q[2] <= 4'd9) && (digit_q[3] <= 4'd9))
    else $error("stored digit out of range");
`endif

endmodule

FILE: tb/tb_seven_segment_mux_driver.sv
// self-checking testbench for the four-digit seven-segment multiplexer
// depends on smd_pkg, smd_in_if, smd_out_if and seven_segment_mux_driver
// directed table first, then randomized numbers and refresh ticks under several settings

module tb_seven_segment_mux_driver;

  localparam int unsigned NumDirected   = 23;
  localparam int unsigned NumSettings   = 12;
  localparam int unsigned ItemsPerSet   = 95;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned WatchdogLimit = 2000;

  // segment patterns of digits 9 down to 0, digit 0 in the low byte
  localparam logic [10*smd_pkg::SegW-1:0] DigitSegs = {8'hfa, 8'hfb, 8'he8, 8'hdb, 8'hda,
                                                       8'h78, 8'hba, 8'hb3, 8'h28, 8'heb};

  typedef struct packed {
    logic [smd_pkg::SegW-1:0]      seg;
    logic [smd_pkg::NumDigits-1:0] gnd;
    logic [smd_pkg::PosW-1:0]      pos;
  } shown_t;

  typedef struct packed {
    smd_pkg::op_e               op;
    logic [smd_pkg::ValueW-1:0] value;
    logic                       typed;
    shown_t                     want;
  } dir_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i;
  smd_pkg::cfg_idx_e            cfg_idx_i;
  logic [smd_pkg::CfgDataW-1:0] cfg_data_i;

  smd_in_if  in_ch ();
  smd_out_if out_ch ();

  seven_segment_mux_driver uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // display model state and settings
  logic [smd_pkg::NumW-1:0] shown_num  = '0;
  logic [smd_pkg::PosW-1:0] scan_pos   = '0;
  logic [smd_pkg::SegW-1:0] seg_last   = '0;
  logic [2:0]               cfg_min    = smd_pkg::MinDigitsRst;
  logic [3:0]               cfg_points = smd_pkg::PointEnableRst;
  logic [2:0]               cfg_dp_bit = smd_pkg::PointBitRst;

  shown_t      pending_digits[$];
  int unsigned send_idle_pct   = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned idle_cycles     = 0;
  int unsigned errors          = 0;
  int unsigned items_sent      = 0;
  int unsigned digits_checked  = 0;
  int unsigned settings_done   = 0;

  always #5 clk_i = ~clk_i;

  // next digit the display shows for one transaction; returns 1 on a refresh tick
  function automatic bit scan_digit(input smd_pkg::op_e op,
                                    input logic [smd_pkg::ValueW-1:0] val,
                                    output shown_t res);
    int unsigned scale;
    int unsigned digit;
    bit          blank;
    res = '0;
    if (op == smd_pkg::OP_SET) begin
      shown_num = (val > smd_pkg::ValueW'(smd_pkg::MaxNumber))
                ? smd_pkg::MaxNumber : val[smd_pkg::NumW-1:0];
      return 1'b0;
    end
    case (scan_pos)
      2'd0:    scale = 1;
      2'd1:    scale = 10;
      2'd2:    scale = 100;
      default: scale = 1000;
    endcase
    // leading zero above the minimum digit count stays dark
    blank = (scan_pos != 2'd0) && (int'(cfg_min) < int'(scan_pos) + 1) &&
            (int'(shown_num) < scale);
    if (blank) begin
      res.gnd = '1;
    end else begin
      digit = (int'(shown_num) / scale) % 10;
      seg_last = DigitSegs[digit*smd_pkg::SegW +: smd_pkg::SegW];
      if (cfg_points[scan_pos]) begin
        seg_last[cfg_dp_bit] = 1'b1;
      end
      res.gnd = ~(4'b0001 << scan_pos);
    end
    res.seg = seg_last;
    res.pos = scan_pos;
    scan_pos = scan_pos + 2'd1;
    return 1'b1;
  endfunction

  // directed stimulus: typed results only where they are plain to see
  function automatic dir_row_t directed_row(input int unsigned i);
    case (i)
      // after reset: digit 0 shows zero, higher digits blanked
      0:  return {smd_pkg::OP_REFRESH, 16'h0000, 1'b1, 8'heb, 4'he, 2'd0};
      1:  return {smd_pkg::OP_REFRESH, 16'hffff, 1'b1, 8'heb, 4'hf, 2'd1};
      2:  return {smd_pkg::OP_REFRESH, 16'h0000, 1'b1, 8'heb, 4'hf, 2'd2};
      3:  return {smd_pkg::OP_REFRESH, 16'haaaa, 1'b1, 8'heb, 4'hf, 2'd3};
      // largest value clamps to 9999
      4:  return {smd_pkg::OP_SET,     16'hffff, 1'b0, 14'd0};
      5:  return {smd_pkg::OP_REFRESH, 16'h0000, 1'b1, 8'hfa, 4'he, 2'd0};
      6:  return {smd_pkg::OP_REFRESH, 16'h5555, 1'b1, 8'hfa, 4'hd, 2'd1};
      7:  return {smd_pkg::OP_REFRESH, 16'h0000, 1'b1, 8'hfa, 4'hb, 2'd2};
      8:  return {smd_pkg::OP_REFRESH, 16'h0000, 1'b1, 8'hfa, 4'h7, 2'd3};
      9:  return {smd_pkg::OP_SET,     16'd10000, 1'b0, 14'd0};
      10: return {smd_pkg::OP_SET,     16'd1234, 1'b0, 14'd0};
      11: return {smd_pkg::OP_REFRESH, 16'h0000, 1'b1, 8'h78, 4'he, 2'd0};
      12: return {smd_pkg::OP_REFRESH, 16'h0000, 1'b1, 8'hba, 4'hd, 2'd1};
      13: return {smd_pkg::OP_REFRESH, 16'h0000, 1'b1, 8'hb3, 4'hb, 2'd2};
      14: return {smd_pkg::OP_REFRESH, 16'h0000, 1'b1, 8'h28, 4'h7, 2'd3};
      15: return {smd_pkg::OP_SET,     16'd5678, 1'b0, 14'd0};
      16: return {smd_pkg::OP_REFRESH, 16'h1234, 1'b0, 14'd0};
      17: return {smd_pkg::OP_REFRESH, 16'h0000, 1'b0, 14'd0};
      18: return {smd_pkg::OP_REFRESH, 16'h0000, 1'b0, 14'd0};
      19: return {smd_pkg::OP_REFRESH, 16'h0000, 1'b0, 14'd0};
      // single digit number: leading zero blanking repeats the last byte
      20: return {smd_pkg::OP_SET,     16'd5, 1'b0, 14'd0};
      21: return {smd_pkg::OP_REFRESH, 16'h0000, 1'b0, 14'd0};
      default: return {smd_pkg::OP_REFRESH, 16'h0000, 1'b0, 14'd0};
    endcase
  endfunction

  // offer one transaction, wait for acceptance, then record its expected digit
  task automatic send_item(input smd_pkg::op_e op, input logic [smd_pkg::ValueW-1:0] val,
                           input bit use_typed, input shown_t typed_res);
    shown_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (scan_digit(op, val, res)) begin
      pending_digits.push_back(use_typed ? typed_res : res);
    end
    items_sent++;
  endtask

  // hold off the sender until every expected digit is out, then let the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all three registers back to back while idle
  task automatic program_display(input logic [2:0] min_dig,
                                 input logic [smd_pkg::CfgDataW-1:0] points,
                                 input logic [2:0] dp_bit);
    for (int k = 0; k < 3; k++) begin
      cfg_we_i <= 1'b1;
      case (k)
        0: begin
          cfg_idx_i  <= smd_pkg::CFG_MIN_DIGITS;
          cfg_data_i <= smd_pkg::CfgDataW'(min_dig);
        end
        1: begin
          cfg_idx_i  <= smd_pkg::CFG_POINT_ENABLE;
          cfg_data_i <= points;
        end
        default: begin
          cfg_idx_i  <= smd_pkg::CFG_POINT_BIT;
          cfg_data_i <= smd_pkg::CfgDataW'(dp_bit);
        end
      endcase
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    cfg_min    = min_dig;
    cfg_points = points;
    cfg_dp_bit = dp_bit;
    settings_done++;
  endtask

  // number spread over every digit count, clamp range and full width
  function automatic logic [smd_pkg::ValueW-1:0] random_number();
    case ($urandom_range(5))
      0:       return smd_pkg::ValueW'($urandom_range(9));
      1:       return smd_pkg::ValueW'($urandom_range(99, 10));
      2:       return smd_pkg::ValueW'($urandom_range(999, 100));
      3:       return smd_pkg::ValueW'($urandom_range(9999, 1000));
      4:       return smd_pkg::ValueW'($urandom_range(65535, 9990));
      default: return smd_pkg::ValueW'($urandom);
    endcase
  endfunction

  // result side stalls
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  // compare each result transaction with the oldest expected digit
  always @(posedge clk_i) begin : check_digits
    shown_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_digits.size() == 0) begin
        errors++;
        $display("%0t: unexpected result seg=%h gnd=%h pos=%0d", $time,
                 out_ch.segments, out_ch.digit_ground_n, out_ch.digit_position);
      end else begin
        want = pending_digits.pop_front();
        digits_checked++;
        if (out_ch.segments !== want.seg) begin
          errors++;
          $display("%0t: segments expected %h got %h", $time, want.seg, out_ch.segments);
        end
        if (out_ch.digit_ground_n !== want.gnd) begin
          errors++;
          $display("%0t: digit_ground_n expected %h got %h", $time, want.gnd,
                   out_ch.digit_ground_n);
        end
        if (out_ch.digit_position !== want.pos) begin
          errors++;
          $display("%0t: digit_position expected %0d got %0d", $time, want.pos,
                   out_ch.digit_position);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles, %0d digits outstanding", $time,
               idle_cycles, pending_digits.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    dir_row_t     row;
    smd_pkg::op_e op;
    in_ch.valid     = 1'b0;
    in_ch.operation = smd_pkg::OP_SET;
    in_ch.value     = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = smd_pkg::CFG_MIN_DIGITS;
    cfg_data_i      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with default settings
    send_idle_pct   = 36;
    ready_stall_pct = 53;
    for (int unsigned i = 0; i < NumDirected; i++) begin
      row = directed_row(i);
      send_item(row.op, row.value, row.typed, row.want);
    end

    // random part: idling mode changes every four settings
    for (int unsigned s = 0; s < NumSettings; s++) begin
      case (s / 4)
        0:       begin send_idle_pct = 36; ready_stall_pct = 53; end
        1:       begin send_idle_pct = 53; ready_stall_pct = 36; end
        default: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
      endcase
      settle();
      case (s)
        0:       program_display(3'd0, 4'h0, 3'd0);
        1:       program_display(3'd7, 4'h7, 3'd7);
        2:       program_display(3'd4, 4'h5, 3'd7);
        3:       program_display(3'd2, 4'ha, 3'd0);
        4:       program_display(3'd1, 4'hf, 3'd2);
        5:       program_display(3'd5, 4'h8, 3'd3);
        default: program_display(3'($urandom_range(7)),
                                 smd_pkg::CfgDataW'($urandom_range(15)),
                                 3'($urandom_range(7)));
      endcase
      for (int unsigned n = 0; n < ItemsPerSet; n++) begin
        op = ($urandom_range(99) < 20) ? smd_pkg::OP_SET : smd_pkg::OP_REFRESH;
        send_item(op, (op == smd_pkg::OP_SET) ? random_number()
                                              : smd_pkg::ValueW'($urandom), 1'b0, '0);
      end
    end

    settle();
    $display("sent %0d transactions, checked %0d digit refreshes", items_sent, digits_checked);
    $display("over %0d register settings and three idling modes", settings_done);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/smd_pkg.sv
design/smd_in_if.sv
design/smd_out_if.sv
design/seven_segment_mux_driver.sv
tb/tb_seven_segment_mux_driver.sv
